>>> sv/cam_pkg.sv
// shared types, codes and defaults for the colormap/alphamap pixel mapper
`timescale 1ns / 1ps
`default_nettype none
package cam_pkg;

  localparam int CM_DEPTH_DEF = 256;
  localparam int AM_DEPTH_DEF = 256;
  // index fields are sized for the largest supported table depth (4096)
  localparam int IDX_MAX_W = 12;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // item kinds (input mode codes)
  localparam logic [1:0] MODE_PIXEL     = 2'd0;
  localparam logic [1:0] MODE_LOAD_CMAP = 2'd1;
  localparam logic [1:0] MODE_LOAD_AMAP = 2'd2;
  // unused code, dropped without a result
  localparam logic [1:0] MODE_IGNORED   = 2'd3;

  // color modes
  localparam logic [2:0] CM_SCALED    = 3'd0;
  localparam logic [2:0] CM_DIR_ONE   = 3'd1;
  localparam logic [2:0] CM_DIR_ZERO  = 3'd2;
  localparam logic [2:0] CM_TRUE_UNIT = 3'd3;
  localparam logic [2:0] CM_TRUE_INT  = 3'd4;

  // alpha modes
  localparam logic [1:0] AM_NONE    = 2'd0;
  localparam logic [1:0] AM_DIR_ONE = 2'd1;
  localparam logic [1:0] AM_SCALED  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_COLOR_MODE   = 3'd0;
  localparam logic [2:0] REG_COLOR_LIM_A  = 3'd1;
  localparam logic [2:0] REG_COLOR_LIM_B  = 3'd2;
  localparam logic [2:0] REG_CMAP_ENTRIES = 3'd3;
  localparam logic [2:0] REG_ALPHA_MODE   = 3'd4;
  localparam logic [2:0] REG_ALPHA_LIM_A  = 3'd5;
  localparam logic [2:0] REG_ALPHA_LIM_B  = 3'd6;
  localparam logic [2:0] REG_AMAP_ENTRIES = 3'd7;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         table_index;
    logic [7:0]         entry_red;
    logic [7:0]         entry_green;
    logic [7:0]         entry_blue;
    logic [7:0]         entry_alpha;
    logic signed [31:0] pixel_value;
    logic signed [31:0] pixel_green;
    logic signed [31:0] pixel_blue;
    logic signed [31:0] pixel_alpha;
  } in_t;

  typedef struct packed {
    logic [31:0] argb_word;
    logic        map_fault;
  } out_t;

  // one table lookup: direct index, or the operands of the scaled division
  typedef struct packed {
    logic                 scaled;
    logic                 neg;
    logic                 top;
    logic [IDX_MAX_W-1:0] idx;
    logic [IDX_MAX_W-1:0] m;
    logic [31:0]          x;
    logic [31:0]          d;
  } lk_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [IDX_MAX_W-1:0] addr;
    logic [23:0]          wdata;
    logic                 fault;
    logic                 c_look;
    logic [23:0]          c_rgb;
    lk_t                  c_lk;
    logic                 a_look;
    logic [7:0]           a_val;
    lk_t                  a_lk;
  } item_t;

endpackage
`default_nettype wire

>>> sv/cam_front.sv
// front end: configuration registers, item accept and classification
`timescale 1ns / 1ps
`default_nettype none
module cam_front #(
  parameter int CM_DEPTH = cam_pkg::CM_DEPTH_DEF,
  parameter int AM_DEPTH = cam_pkg::AM_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cam_pkg::in_t   in_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output logic           q_valid,
  input  logic           q_ready,
  output cam_pkg::item_t q_item
);

  localparam int CLW = $clog2(CM_DEPTH + 1);
  localparam int ALW = $clog2(AM_DEPTH + 1);
  localparam int IW  = cam_pkg::IDX_MAX_W;

  logic [2:0]         color_mode_r;
  logic signed [31:0] c_lim_a_r, c_lim_b_r;
  logic [8:0]         c_ent_r;
  logic [1:0]         alpha_mode_r;
  logic signed [31:0] a_lim_a_r, a_lim_b_r;
  logic [8:0]         a_ent_r;

  logic               f_valid_r, f_valid_nxt;
  cam_pkg::item_t     f_item_r, item;
  logic               keep;
  logic [CLW-1:0]     clen;
  logic [ALW-1:0]     alen;
  logic [IW-1:0]      c_lm1, a_lm1;
  logic [16:0]        ac;
  logic [24:0]        ap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= cam_pkg::CM_SCALED;
      c_lim_a_r    <= 32'sd0;
      c_lim_b_r    <= 32'sd65536;
      c_ent_r      <= 9'd0;
      alpha_mode_r <= cam_pkg::AM_NONE;
      a_lim_a_r    <= 32'sd0;
      a_lim_b_r    <= 32'sd65536;
      a_ent_r      <= 9'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cam_pkg::REG_COLOR_MODE:   color_mode_r <= cfg_data[2:0];
        cam_pkg::REG_COLOR_LIM_A:  c_lim_a_r    <= cfg_data;
        cam_pkg::REG_COLOR_LIM_B:  c_lim_b_r    <= cfg_data;
        cam_pkg::REG_CMAP_ENTRIES: c_ent_r      <= cfg_data[8:0];
        cam_pkg::REG_ALPHA_MODE:   alpha_mode_r <= cfg_data[1:0];
        cam_pkg::REG_ALPHA_LIM_A:  a_lim_a_r    <= cfg_data;
        cam_pkg::REG_ALPHA_LIM_B:  a_lim_b_r    <= cfg_data;
        cam_pkg::REG_AMAP_ENTRIES: a_ent_r      <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Q16.16 to integer, toward zero
  function automatic logic signed [16:0] trunc_q(input logic signed [31:0] v);
    logic signed [32:0] vx;
    vx = 33'(v) + ((v < 0) ? 33'sh0FFFF : 33'sd0);
    return 17'(vx >>> 16);
  endfunction

  function automatic logic [7:0] unit_ch(input logic signed [31:0] v);
    logic signed [40:0] p;
    p = (41'(v) <<< 8) - 41'(v);
    p = p + ((p < 0) ? 41'sh0FFFF : 41'sd0);
    return p[23:16];
  endfunction

  function automatic logic [7:0] int_ch(input logic signed [31:0] v);
    logic signed [16:0] t;
    t = trunc_q(v);
    return t[7:0];
  endfunction

  function automatic logic [IW-1:0] dir_idx(input logic signed [16:0] t, input logic one,
                                             input logic [IW-1:0] lm1);
    logic signed [17:0] s;
    s = 18'(t) - (one ? 18'sd1 : 18'sd0);
    if (s < 0) return '0;
    else if (s > $signed(18'(lm1))) return lm1;
    else return s[IW-1:0];
  endfunction

  function automatic cam_pkg::lk_t mk_lk(input logic scaled, input logic one,
                                         input logic signed [31:0] v,
                                         input logic signed [31:0] la,
                                         input logic signed [31:0] lb,
                                         input logic [IW-1:0] lm1);
    cam_pkg::lk_t       r;
    logic signed [31:0] lo, hi;
    logic signed [32:0] diff, dd;
    lo       = (la < lb) ? la : lb;
    hi       = (la < lb) ? lb : la;
    diff     = 33'(v) - 33'(lo);
    dd       = 33'(hi) - 33'(lo);
    r.scaled = scaled;
    r.neg    = diff < 0;
    r.top    = v >= hi;
    r.idx    = dir_idx(trunc_q(v), one, lm1);
    r.m      = lm1;
    r.x      = diff[31:0];
    r.d      = dd[31:0];
    return r;
  endfunction

  always_comb begin
    clen  = (32'(c_ent_r) > CM_DEPTH) ? CLW'(CM_DEPTH) : CLW'(c_ent_r);
    alen  = (32'(a_ent_r) > AM_DEPTH) ? ALW'(AM_DEPTH) : ALW'(a_ent_r);
    c_lm1 = IW'(clen - CLW'(1));
    a_lm1 = IW'(alen - ALW'(1));

    // alpha without a table: clamp to [0,1] and scale by 255
    if (in_data.pixel_alpha < 0) ac = 17'd0;
    else if (in_data.pixel_alpha > 32'sd65536) ac = 17'h10000;
    else ac = in_data.pixel_alpha[16:0];
    ap = (25'(ac) << 8) - 25'(ac);

    item = '0;
    keep = 1'b0;
    case (in_data.mode)
      cam_pkg::MODE_PIXEL: begin
        keep      = 1'b1;
        item.kind = cam_pkg::MODE_PIXEL;
        if (color_mode_r == cam_pkg::CM_TRUE_UNIT) begin
          item.c_rgb = {unit_ch(in_data.pixel_value), unit_ch(in_data.pixel_green),
                        unit_ch(in_data.pixel_blue)};
        end else if (color_mode_r == cam_pkg::CM_TRUE_INT) begin
          item.c_rgb = {int_ch(in_data.pixel_value), int_ch(in_data.pixel_green),
                        int_ch(in_data.pixel_blue)};
        end else if (c_lim_a_r == c_lim_b_r || clen == '0) begin
          item.fault = 1'b1;
        end else begin
          item.c_look = 1'b1;
          item.c_lk   = mk_lk(!(color_mode_r inside {cam_pkg::CM_DIR_ONE, cam_pkg::CM_DIR_ZERO}),
                              color_mode_r == cam_pkg::CM_DIR_ONE, in_data.pixel_value,
                              c_lim_a_r, c_lim_b_r, c_lm1);
        end
        if (alpha_mode_r == cam_pkg::AM_NONE) begin
          item.a_val = ap[23:16];
        end else if (alen == '0 ||
                     (alpha_mode_r != cam_pkg::AM_DIR_ONE && a_lim_a_r == a_lim_b_r)) begin
          item.fault = 1'b1;
        end else begin
          item.a_look = 1'b1;
          item.a_lk   = mk_lk(alpha_mode_r != cam_pkg::AM_DIR_ONE, 1'b1, in_data.pixel_alpha,
                              a_lim_a_r, a_lim_b_r, a_lm1);
        end
      end
      cam_pkg::MODE_LOAD_CMAP: begin
        keep       = 32'(in_data.table_index) < CM_DEPTH;
        item.kind  = cam_pkg::MODE_LOAD_CMAP;
        item.addr  = IW'(in_data.table_index);
        item.wdata = {in_data.entry_red, in_data.entry_green, in_data.entry_blue};
      end
      cam_pkg::MODE_LOAD_AMAP: begin
        keep       = 32'(in_data.table_index) < AM_DEPTH;
        item.kind  = cam_pkg::MODE_LOAD_AMAP;
        item.addr  = IW'(in_data.table_index);
        item.wdata = {16'd0, in_data.entry_alpha};
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = !f_valid_r || q_ready;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (f_valid_r && q_ready) f_valid_nxt = 1'b0;
    if (in_valid && in_ready) f_valid_nxt = keep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) f_item_r <= item;
  end

  assign q_valid = f_valid_r;
  assign q_item  = f_item_r;

endmodule
`default_nettype wire

>>> sv/cam_queue.sv
// short item queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module cam_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  cam_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cam_pkg::item_t pop_item
);

  cam_pkg::item_t                  buf_r [0:cam_pkg::Q_DEPTH-1];
  logic [cam_pkg::Q_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [cam_pkg::Q_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign push_ready = cnt_r != cam_pkg::Q_CNT_W'(cam_pkg::Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = buf_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) buf_r[wr_ptr_r] <= push_item;
  end

endmodule
`default_nettype wire

>>> sv/cam_div.sv
// pipelined multiply then restoring divide, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module cam_div #(
  parameter int W = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   x,
  input  logic [W-1:0]  m,
  input  logic [31:0]   d,
  output logic [W-1:0]  q
);

  localparam int NW = 32 + W;

  logic [NW-1:0] rem_r [0:W];
  logic [31:0]   dv_r  [0:W];
  logic [W-1:0]  q_r   [0:W];

  // x < d, so the quotient of x*m by d stays below m
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= NW'(x) * NW'(m);
      dv_r[0]  <= d;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [NW-1:0] sub;
    logic          ge;
    assign sub = NW'(dv_r[k-1]) << (W - k);
    assign ge  = rem_r[k-1] >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? rem_r[k-1] - sub : rem_r[k-1];
        dv_r[k]  <= dv_r[k-1];
        q_r[k]   <= q_r[k-1] | (ge ? (W'(1) << (W - k)) : '0);
      end
    end
  end

  assign q = q_r[W];

endmodule
`default_nettype wire

>>> sv/cam_back.sv
// back end: scaled index division, table memories and result register
`timescale 1ns / 1ps
`default_nettype none
module cam_back #(
  parameter int CM_DEPTH = cam_pkg::CM_DEPTH_DEF,
  parameter int AM_DEPTH = cam_pkg::AM_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  cam_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output cam_pkg::out_t  out_data
);

  localparam int CIW = $clog2(CM_DEPTH);
  localparam int AIW = $clog2(AM_DEPTH);
  localparam int DW  = (CIW > AIW) ? CIW : AIW;
  localparam int IW  = cam_pkg::IDX_MAX_W;

  logic           adv;
  cam_pkg::item_t sb_r [0:DW];
  logic [DW:0]    sb_v_r;
  cam_pkg::item_t it, m_r;
  logic           m_v_r;
  logic [DW-1:0]  c_q, a_q;
  logic [IW-1:0]  c_idx, a_idx;
  logic [23:0]    cmem [0:CM_DEPTH-1];
  logic [7:0]     amem [0:AM_DEPTH-1];
  logic [23:0]    c_rd_r;
  logic [7:0]     a_rd_r;
  logic           out_valid_r;
  cam_pkg::out_t  out_data_r;

  // whole pipeline moves together; stalls only when the result is not taken
  assign adv     = !out_valid_r || out_ready;
  assign q_ready = adv;

  cam_div #(.W(DW)) u_cdiv (
    .clk (clk),
    .en  (adv),
    .x   (q_item.c_lk.x),
    .m   (q_item.c_lk.m[DW-1:0]),
    .d   (q_item.c_lk.d),
    .q   (c_q)
  );

  cam_div #(.W(DW)) u_adiv (
    .clk (clk),
    .en  (adv),
    .x   (q_item.a_lk.x),
    .m   (q_item.a_lk.m[DW-1:0]),
    .d   (q_item.a_lk.d),
    .q   (a_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_v_r <= '0;
    end else if (adv) begin
      sb_v_r <= {sb_v_r[DW-1:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= q_item;
      for (int k = 1; k <= DW; k++) sb_r[k] <= sb_r[k-1];
    end
  end

  function automatic logic [IW-1:0] sel_idx(input cam_pkg::lk_t lk, input logic [DW-1:0] qv);
    if (!lk.scaled) return lk.idx;
    else if (lk.neg) return '0;
    else if (lk.top) return lk.m;
    else return IW'(qv);
  endfunction

  assign it    = sb_r[DW];
  assign c_idx = sel_idx(it.c_lk, c_q);
  assign a_idx = sel_idx(it.a_lk, a_q);

  // table writes travel in order with pixels, so a later pixel sees them
  always_ff @(posedge clk) begin
    if (adv) begin
      if (sb_v_r[DW] && it.kind == cam_pkg::MODE_LOAD_CMAP) cmem[it.addr[CIW-1:0]] <= it.wdata;
      c_rd_r <= cmem[c_idx[CIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sb_v_r[DW] && it.kind == cam_pkg::MODE_LOAD_AMAP)
        amem[it.addr[AIW-1:0]] <= it.wdata[7:0];
      a_rd_r <= amem[a_idx[AIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m_v_r       <= sb_v_r[DW];
      out_valid_r <= m_v_r && m_r.kind == cam_pkg::MODE_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r                  <= it;
      out_data_r.argb_word <= {m_r.a_look ? a_rd_r : m_r.a_val,
                               m_r.c_look ? c_rd_r : m_r.c_rgb};
      out_data_r.map_fault <= m_r.fault;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> sv/colormap_alphamap_pixel_mapper.sv
// top level of the colormap/alphamap pixel mapper
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_ready    cam_pkg::in_t (pixel or table load)
//   out_      output     out_valid / out_ready  cam_pkg::out_t (argb word, fault)
//   cfg_      input      cfg_valid / cfg_ready  cfg_index (3b), cfg_data (32b)
//
// one item per clock unless the output stalls; the scaled index divider gives D
// quotient bits, D = clog2 of the larger table depth (one quotient bit per divider stage)
// table loads flow down the same pipeline and give no result
// sync active-low reset clears control state; table contents are not cleared
// a stalled output freezes the back pipeline; the four-entry queue keeps the front going until it fills
`timescale 1ns / 1ps
`default_nettype none
module colormap_alphamap_pixel_mapper #(
  parameter int CM_DEPTH = cam_pkg::CM_DEPTH_DEF,
  parameter int AM_DEPTH = cam_pkg::AM_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cam_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cam_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  logic           f_valid, f_ready, b_valid, b_ready;
  cam_pkg::item_t f_item, b_item;

  cam_front #(.CM_DEPTH(CM_DEPTH), .AM_DEPTH(AM_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_item    (f_item)
  );

  cam_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  cam_back #(.CM_DEPTH(CM_DEPTH), .AM_DEPTH(AM_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_item    (b_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> sv/cam_checker.sv
// port-level checks for the pixel mapper, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module cam_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input cam_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input cam_pkg::out_t out_data,
  input logic          cfg_valid,
  input logic          cfg_ready,
  input logic [2:0]    cfg_index,
  input logic [31:0]   cfg_data
);

  logic [2:0] cm_r;
  logic [1:0] am_r;
  logic [7:0] pend_r, pend_nxt;
  logic       pix_in, res_out, truecolor;

  assign pix_in    = in_valid && in_ready && in_data.mode == cam_pkg::MODE_PIXEL;
  assign res_out   = out_valid && out_ready;
  assign truecolor = cm_r == cam_pkg::CM_TRUE_UNIT || cm_r == cam_pkg::CM_TRUE_INT;

  always_comb begin
    pend_nxt = pend_r;
    if (pix_in && !res_out) pend_nxt = pend_r + 1'b1;
    else if (res_out && !pix_in) pend_nxt = pend_r - 1'b1;
  end

  // shadow of the mode registers and the count of pending pixels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cm_r   <= cam_pkg::CM_SCALED;
      am_r   <= cam_pkg::AM_NONE;
      pend_r <= 8'd0;
    end else begin
      pend_r <= pend_nxt;
      if (cfg_valid && cfg_ready && cfg_index == cam_pkg::REG_COLOR_MODE) cm_r <= cfg_data[2:0];
      if (cfg_valid && cfg_ready && cfg_index == cam_pkg::REG_ALPHA_MODE) am_r <= cfg_data[1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 8'd0)
    else $error("result without a pending pixel");

  a_true_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && truecolor && am_r == cam_pkg::AM_NONE |-> !out_data.map_fault)
    else $error("fault in truecolor mode without alpha table");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.map_fault && !truecolor && am_r == cam_pkg::AM_NONE
      |-> out_data.argb_word[23:0] == 24'd0)
    else $error("color fault with nonzero color");

endmodule

bind colormap_alphamap_pixel_mapper cam_checker u_cam_checker (.*);
`default_nettype wire

>>> sim/tb_colormap_alphamap_pixel_mapper.sv
// testbench for the colormap/alphamap pixel mapper: random traffic checked by a scoreboard
`timescale 1ns / 1ps
module tb_colormap_alphamap_pixel_mapper;

  class argb_scoreboard;
    logic [2:0]    color_mode;
    longint        clim_a, clim_b;
    int            cmap_len;
    logic [1:0]    alpha_mode;
    longint        alim_a, alim_b;
    int            amap_len;
    logic [23:0]   cmap [256];
    logic [7:0]    amap [256];
    cam_pkg::out_t pending_words [$];
    int            mismatches;

    function new();
      color_mode = cam_pkg::CM_SCALED;
      clim_a = 0;
      clim_b = 65536;
      cmap_len = 0;
      alpha_mode = cam_pkg::AM_NONE;
      alim_a = 0;
      alim_b = 65536;
      amap_len = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        cam_pkg::REG_COLOR_MODE:   color_mode = data[2:0];
        cam_pkg::REG_COLOR_LIM_A:  clim_a = longint'($signed(data));
        cam_pkg::REG_COLOR_LIM_B:  clim_b = longint'($signed(data));
        cam_pkg::REG_CMAP_ENTRIES: cmap_len = data[8:0];
        cam_pkg::REG_ALPHA_MODE:   alpha_mode = data[1:0];
        cam_pkg::REG_ALPHA_LIM_A:  alim_a = longint'($signed(data));
        cam_pkg::REG_ALPHA_LIM_B:  alim_b = longint'($signed(data));
        cam_pkg::REG_AMAP_ENTRIES: amap_len = data[8:0];
        default: ;
      endcase
    endfunction

    // q16.16 to integer, toward zero
    function longint q_int(longint v);
      return (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
    endfunction

    function longint clamp_idx(longint i, longint len);
      if (i < 0) return 0;
      if (i > len - 1) return len - 1;
      return i;
    endfunction

    function longint scaled_idx(longint v, longint la, longint lb, longint len);
      longint lo, hi;
      lo = (la < lb) ? la : lb;
      hi = (la < lb) ? lb : la;
      return clamp_idx(((v - lo) * (len - 1)) / (hi - lo), len);
    endfunction

    function void note_item(cam_pkg::in_t it);
      cam_pkg::out_t w;
      longint v, va, clen, alen, idx, c;
      logic [7:0] r, g, b, a;
      logic fault;
      if (it.mode == cam_pkg::MODE_LOAD_CMAP) begin
        cmap[it.table_index] = {it.entry_red, it.entry_green, it.entry_blue};
        return;
      end
      if (it.mode == cam_pkg::MODE_LOAD_AMAP) begin
        amap[it.table_index] = it.entry_alpha;
        return;
      end
      if (it.mode != cam_pkg::MODE_PIXEL) return;
      v = longint'(it.pixel_value);
      va = longint'(it.pixel_alpha);
      clen = (cmap_len > 256) ? 256 : cmap_len;
      alen = (amap_len > 256) ? 256 : amap_len;
      r = 0; g = 0; b = 0; a = 0; fault = 0;
      if (color_mode == cam_pkg::CM_TRUE_UNIT) begin
        r = 8'(q_int(255 * v));
        g = 8'(q_int(255 * longint'(it.pixel_green)));
        b = 8'(q_int(255 * longint'(it.pixel_blue)));
      end else if (color_mode == cam_pkg::CM_TRUE_INT) begin
        r = 8'(q_int(v));
        g = 8'(q_int(longint'(it.pixel_green)));
        b = 8'(q_int(longint'(it.pixel_blue)));
      end else if (clim_a == clim_b || clen == 0) begin
        fault = 1;
      end else begin
        if (color_mode == cam_pkg::CM_DIR_ONE) idx = clamp_idx(q_int(v) - 1, clen);
        else if (color_mode == cam_pkg::CM_DIR_ZERO) idx = clamp_idx(q_int(v), clen);
        else idx = scaled_idx(v, clim_a, clim_b, clen);
        {r, g, b} = cmap[idx];
      end
      if (alpha_mode == cam_pkg::AM_NONE) begin
        c = (va < 0) ? 0 : ((va > 65536) ? 65536 : va);
        a = 8'((255 * c) >>> 16);
      end else if (alen == 0 || (alpha_mode != cam_pkg::AM_DIR_ONE && alim_a == alim_b)) begin
        fault = 1;
      end else begin
        if (alpha_mode == cam_pkg::AM_DIR_ONE) idx = clamp_idx(q_int(va) - 1, alen);
        else idx = scaled_idx(va, alim_a, alim_b, alen);
        a = amap[idx];
      end
      w.argb_word = {a, r, g, b};
      w.map_fault = fault;
      pending_words = {pending_words, w};
    endfunction

    function void check_word(cam_pkg::out_t got);
      cam_pkg::out_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%b", got.argb_word, got.map_fault);
        return;
      end
      want = pending_words.pop_front();
      if (got.argb_word !== want.argb_word || got.map_fault !== want.map_fault) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: argb exp %h got %h, fault exp %b got %b",
                   want.argb_word, got.argb_word, want.map_fault, got.map_fault);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  cam_pkg::in_t  in_data;
  cam_pkg::out_t out_data;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int ready_pct;
  argb_scoreboard sb;

  colormap_alphamap_pixel_mapper u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
    out_ready <= ($urandom_range(0, 99) < ready_pct);
  end

  // leaves in_valid high so a following item can go on the next edge
  task automatic push_item(cam_pkg::in_t it);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_q(longint near_lo, longint near_hi);
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return ($urandom_range(0, 600) - 300) * 65536 + $urandom_range(0, 65535);
      2: return $urandom_range(0, 131072) - 32768;
      3: return 32'(near_lo + $urandom_range(0, 4096) - 2048);
      default: return 32'(near_hi + $urandom_range(0, 4096) - 2048);
    endcase
  endfunction

  function automatic cam_pkg::in_t rand_item();
    cam_pkg::in_t it;
    int           k;
    logic [191:0] rb;
    rb = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = rb[$bits(cam_pkg::in_t)-1:0];
    k = $urandom_range(0, 99);
    if (k < 6) it.mode = cam_pkg::MODE_LOAD_CMAP;
    else if (k < 10) it.mode = cam_pkg::MODE_LOAD_AMAP;
    else if (k < 12) it.mode = cam_pkg::MODE_IGNORED;
    else begin
      it.mode = cam_pkg::MODE_PIXEL;
      it.pixel_value = pick_q(sb.clim_a, sb.clim_b);
      it.pixel_green = pick_q(0, 65536);
      it.pixel_blue = pick_q(0, 65536);
      it.pixel_alpha = pick_q(sb.alim_a, sb.alim_b);
    end
    return it;
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return ($urandom_range(0, 40) - 20) * 65536 + $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return 256;
      3: return $urandom_range(257, 511);
      default: return $urandom_range(2, 255);
    endcase
  endfunction

  initial begin
    cam_pkg::in_t it;
    int           gap, burst;
    logic [31:0]  la;
    logic [191:0] rb;
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = cam_pkg::REG_COLOR_MODE;
    cfg_data = '0;
    out_ready = 0;
    ready_pct = 100;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill both tables so no lookup ever hits an unwritten entry
    for (int i = 0; i < 256; i++) begin
      rb = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = rb[$bits(cam_pkg::in_t)-1:0];
      it.mode = cam_pkg::MODE_LOAD_CMAP;
      it.table_index = 8'(i);
      push_item(it);
      it.mode = cam_pkg::MODE_LOAD_AMAP;
      push_item(it);
    end

    // reset settings: scaled color with empty table faults, alpha clamps
    foreach (la[i]) begin
      it = '0;
      it.mode = cam_pkg::MODE_PIXEL;
      it.pixel_value = $urandom;
      it.pixel_alpha = (i % 4 == 0) ? 32'h8000_0000 : (i % 4 == 1) ? 32'h7fff_ffff :
                       (i % 4 == 2) ? 32'h0001_0000 : $urandom_range(0, 65536);
      push_item(it);
    end
    it.mode = cam_pkg::MODE_IGNORED;
    push_item(it);
    drain_wait();

    for (int ph = 0; ph < 14; ph++) begin
      ready_pct = (ph % 4 == 0) ? 100 : $urandom_range(25, 95);
      if (ph < 8) set_reg(cam_pkg::REG_COLOR_MODE, ph);
      else set_reg(cam_pkg::REG_COLOR_MODE, $urandom_range(0, 7));
      la = pick_limit();
      set_reg(cam_pkg::REG_COLOR_LIM_A, la);
      set_reg(cam_pkg::REG_COLOR_LIM_B, (ph == 5) ? la : pick_limit());
      set_reg(cam_pkg::REG_CMAP_ENTRIES,
              (ph == 1) ? 0 : (ph == 2) ? 1 : (ph == 3) ? 511 : pick_len());
      set_reg(cam_pkg::REG_ALPHA_MODE, ph % 4);
      la = pick_limit();
      set_reg(cam_pkg::REG_ALPHA_LIM_A, la);
      set_reg(cam_pkg::REG_ALPHA_LIM_B, (ph == 6) ? la : pick_limit());
      set_reg(cam_pkg::REG_AMAP_ENTRIES, (ph == 7) ? 0 : (ph == 9) ? 1 : pick_len());
      cfg_valid <= 1'b0;
      for (int n = 0; n < 80; n += burst) begin
        burst = $urandom_range(1, 20);
        for (int j = 0; j < burst; j++) push_item(rand_item());
        if (ph == 2 && n >= 40 && n < 80) begin
          in_valid <= 1'b0;
          while (sb.pending_words.size() != 0) @(posedge clk);
        end else if ($urandom_range(0, 2) != 0) begin
          gap = $urandom_range(1, 6);
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      drain_wait();
    end

    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
